FILE: rtl/ked_pkg.sv
// ked_pkg: shared widths, codes, reset values and types for the key event detector.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ked_pkg;

  // Field widths
  localparam int LEVEL_W   = 4;   // raw level bits carried by a tick request
  localparam int KEY_IDX_W = 2;
  localparam int SEL_W     = 3;
  localparam int FLAG_W    = 7;
  localparam int CNT_W     = 16;
  localparam int SCAN_W    = 8;
  localparam int PHASE_W   = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int NUM_KEYS_DEF = 4;

  // Request kinds carried in tuser
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // Event flag positions, equal to the event select codes
  localparam logic [SEL_W-1:0] EV_HOLD   = 3'd0;
  localparam logic [SEL_W-1:0] EV_DOWN   = 3'd1;
  localparam logic [SEL_W-1:0] EV_UP     = 3'd2;
  localparam logic [SEL_W-1:0] EV_SINGLE = 3'd3;
  localparam logic [SEL_W-1:0] EV_DOUBLE = 3'd4;
  localparam logic [SEL_W-1:0] EV_LONG   = 3'd5;
  localparam logic [SEL_W-1:0] EV_REPEAT = 3'd6;
  localparam logic [SEL_W-1:0] EV_NONE   = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCAN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT = 2'd3;

  // Configuration reset values
  localparam logic [SCAN_W-1:0] SCAN_RST   = 8'd20;
  localparam logic [CNT_W-1:0]  LONG_RST   = 16'd2000;
  localparam logic [CNT_W-1:0]  DOUBLE_RST = 16'd200;
  localparam logic [CNT_W-1:0]  REPEAT_RST = 16'd100;

  // Timer reload values shared by all lanes
  typedef struct packed {
    logic [CNT_W-1:0] long_ticks;
    logic [CNT_W-1:0] double_ticks;
    logic [CNT_W-1:0] repeat_ticks;
  } ked_cfg_t;

  // Per-request control broadcast to all lanes and the merge stage
  typedef struct packed {
    logic                 tick;    // accepted tick request
    logic                 sample;  // this tick samples the levels
    logic                 check;   // accepted check request
    logic [KEY_IDX_W-1:0] key;
    logic [SEL_W-1:0]     sel;
  } ked_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/key_event_detector.sv
// Key event detector: one lane per key, a sample counter, configuration
// registers and a merge stage with the output register. Depends on ked_pkg.
//
// Takes one request per clock: a tick (tuser 0) advances all key timers and,
// every scan_period ticks, samples the key levels; a check (tuser 1) reports
// and consumes one pending event of one key. Every request yields one result
// in the cycle after acceptance, held in a single output register; a new request
// is taken in the same cycle that the previous result is taken, so the rate is
// one request per cycle while out_tready stays high. All keys update in
// parallel lanes within that cycle. Configuration writes take effect at once
// and are always accepted; write them only while no request is in flight.
`default_nettype none

module key_event_detector #(
  parameter int NUM_KEYS = ked_pkg::NUM_KEYS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: [3:0] key_levels, [5:4] key_index, [8:6] event_select, rest zero
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [ked_pkg::IN_DATA_W-1:0]       in_tdata,
  // in_tuser: [0] action (0 tick, 1 check)
  input  wire logic                                in_tuser,
  // out_tdata: [0] event_hit, [7:1] pending_flags
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [ked_pkg::OUT_DATA_W-1:0]           out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ked_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ked_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic                         accept;
  logic [ked_pkg::LEVEL_W-1:0]  levels;
  ked_pkg::ked_ctrl_t           ctrl;
  ked_pkg::ked_cfg_t            cfg;
  logic [ked_pkg::SCAN_W-1:0]   scan_r;
  logic [ked_pkg::CNT_W-1:0]    long_r, double_r, repeat_r;
  logic [ked_pkg::SCAN_W-1:0]   scnt_r, scnt_inc;
  logic [ked_pkg::FLAG_W-1:0]   flags_cur [NUM_KEYS];
  logic [ked_pkg::FLAG_W-1:0]   flags_nxt [NUM_KEYS];

  assign accept   = in_tvalid && in_tready;
  assign levels   = in_tdata[3:0];
  assign scnt_inc = scnt_r + 1'b1;

  // Decode the request into lane control
  assign ctrl.tick   = accept && (in_tuser == ked_pkg::ACT_TICK);
  assign ctrl.sample = ctrl.tick && (scnt_inc == scan_r);
  assign ctrl.check  = accept && (in_tuser == ked_pkg::ACT_CHECK);
  assign ctrl.key    = in_tdata[5:4];
  assign ctrl.sel    = in_tdata[8:6];

  assign cfg.long_ticks   = long_r;
  assign cfg.double_ticks = double_r;
  assign cfg.repeat_ticks = repeat_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= ked_pkg::SCAN_RST;
      long_r   <= ked_pkg::LONG_RST;
      double_r <= ked_pkg::DOUBLE_RST;
      repeat_r <= ked_pkg::REPEAT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ked_pkg::REG_SCAN:   scan_r   <= cfg_data[ked_pkg::SCAN_W-1:0];
        ked_pkg::REG_LONG:   long_r   <= cfg_data;
        ked_pkg::REG_DOUBLE: double_r <= cfg_data;
        ked_pkg::REG_REPEAT: repeat_r <= cfg_data;
        default: begin
          scan_r <= scan_r;
        end
      endcase
    end
  end

  // Advance the sample counter on each tick, wrap to zero on a sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scnt_r <= '0;
    end else if (ctrl.tick) begin
      scnt_r <= ctrl.sample ? '0 : scnt_inc;
    end
  end

  // One lane per key; keys past the level field read unpressed
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic lane_level;
    if (k < ked_pkg::LEVEL_W) begin : g_lvl
      assign lane_level = levels[k];
    end else begin : g_nolvl
      assign lane_level = 1'b0;
    end
    ked_lane #(
      .KEY_ID (k)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .level     (lane_level),
      .flags_cur (flags_cur[k]),
      .flags_nxt (flags_nxt[k])
    );
  end

  ked_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .accept    (accept),
    .flags_cur (flags_cur),
    .flags_nxt (flags_nxt),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/ked_lane.sv
// ked_lane: per-key core with level history, click phase machine, countdown and flags.
// Depends on ked_pkg; one copy per key in key_event_detector.
`default_nettype none

module ked_lane #(
  parameter int KEY_ID = 0
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ked_pkg::ked_ctrl_t         ctrl,
  input  wire ked_pkg::ked_cfg_t          cfg,
  input  wire logic                       level,
  output logic [ked_pkg::FLAG_W-1:0]      flags_cur,
  output logic [ked_pkg::FLAG_W-1:0]      flags_nxt
);

  localparam logic [ked_pkg::PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [ked_pkg::PHASE_W-1:0] PH_PRESSED = 3'd1;
  localparam logic [ked_pkg::PHASE_W-1:0] PH_WAIT2   = 3'd2;
  localparam logic [ked_pkg::PHASE_W-1:0] PH_SECOND  = 3'd3;
  localparam logic [ked_pkg::PHASE_W-1:0] PH_REPEAT  = 3'd4;

  logic                          cur_r, cur_nxt;
  logic                          prev_r, prev_nxt;
  logic [ked_pkg::PHASE_W-1:0]   phase_r, phase_nxt;
  logic [ked_pkg::CNT_W-1:0]     cd_r, cd_nxt, cd_dec;
  logic [ked_pkg::FLAG_W-1:0]    flags_r, f;
  logic                          cd_zero;
  logic                          key_hit;

  assign cd_dec  = (cd_r != '0) ? cd_r - 1'b1 : cd_r;
  assign cd_zero = (cd_dec == '0);
  assign key_hit = ctrl.check && (int'(ctrl.key) == KEY_ID);

  // Next state: countdown first, then the sample step, or a flag consume
  always_comb begin
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    phase_nxt = phase_r;
    cd_nxt    = cd_r;
    f         = flags_r;
    if (ctrl.tick) begin
      cd_nxt = cd_dec;
      if (ctrl.sample) begin
        prev_nxt = cur_r;
        cur_nxt  = level;
        f[ked_pkg::EV_HOLD] = level;
        if (level && !cur_r) f[ked_pkg::EV_DOWN] = 1'b1;
        if (!level && cur_r) f[ked_pkg::EV_UP] = 1'b1;
        unique case (phase_r)
          PH_IDLE: begin
            if (level) begin
              cd_nxt    = cfg.long_ticks;
              phase_nxt = PH_PRESSED;
            end
          end
          PH_PRESSED: begin
            if (!level) begin
              cd_nxt    = cfg.double_ticks;
              phase_nxt = PH_WAIT2;
            end else if (cd_zero) begin
              cd_nxt    = cfg.repeat_ticks;
              f[ked_pkg::EV_LONG] = 1'b1;
              phase_nxt = PH_REPEAT;
            end
          end
          PH_WAIT2: begin
            if (level) begin
              f[ked_pkg::EV_DOUBLE] = 1'b1;
              phase_nxt = PH_SECOND;
            end else if (cd_zero) begin
              f[ked_pkg::EV_SINGLE] = 1'b1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_SECOND: begin
            if (!level) phase_nxt = PH_IDLE;
          end
          PH_REPEAT: begin
            if (!level) begin
              phase_nxt = PH_IDLE;
            end else if (cd_zero) begin
              cd_nxt = cfg.repeat_ticks;
              f[ked_pkg::EV_REPEAT] = 1'b1;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end else if (key_hit && ctrl.sel != ked_pkg::EV_HOLD && ctrl.sel != ked_pkg::EV_NONE) begin
      // consume one event; hold only follows the level
      f = flags_r & ~(ked_pkg::FLAG_W'(1) << ctrl.sel);
    end
  end

  assign flags_cur = flags_r;
  assign flags_nxt = f;

  // Hold lane state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= 1'b0;
      prev_r  <= 1'b0;
      phase_r <= PH_IDLE;
      cd_r    <= '0;
      flags_r <= '0;
    end else begin
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      phase_r <= phase_nxt;
      cd_r    <= cd_nxt;
      flags_r <= f;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ked_merge.sv
// ked_merge: selects the indexed key's flags from all lanes, forms the hit bit,
// and holds the result in the output register. Depends on ked_pkg.
`default_nettype none

module ked_merge #(
  parameter int NUM_KEYS = ked_pkg::NUM_KEYS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ked_pkg::ked_ctrl_t            ctrl,
  input  wire logic                          accept,
  input  wire logic [ked_pkg::FLAG_W-1:0]    flags_cur [NUM_KEYS],
  input  wire logic [ked_pkg::FLAG_W-1:0]    flags_nxt [NUM_KEYS],
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ked_pkg::OUT_DATA_W-1:0]     out_data
);

  logic [ked_pkg::FLAG_W-1:0]     pick_cur, pick_nxt;
  logic                           hit;
  logic                           valid_r;
  logic [ked_pkg::OUT_DATA_W-1:0] data_r;

  // Select the addressed key; keys beyond the lanes read as zero
  always_comb begin
    pick_cur = '0;
    pick_nxt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (int'(ctrl.key) == k) begin
        pick_cur = flags_cur[k];
        pick_nxt = flags_nxt[k];
      end
    end
  end

  assign hit = ctrl.check && (ctrl.sel != ked_pkg::EV_NONE) &&
               (|(pick_cur & (ked_pkg::FLAG_W'(1) << ctrl.sel)));

  // Take a new request whenever the output slot is empty or draining
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= {pick_nxt, hit};
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: rtl/ked_checker.sv
// ked_checker: port-level assertions for key_event_detector, bound to the top level.
// Depends on ked_pkg.
`default_nettype none

module ked_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic [ked_pkg::IN_DATA_W-1:0]       in_tdata,
  input wire logic                                in_tuser,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ked_pkg::OUT_DATA_W-1:0]      out_tdata,
  input wire logic                                cfg_valid,
  input wire logic                                cfg_ready,
  input wire logic [ked_pkg::CFG_IDX_W-1:0]       cfg_index,
  input wire logic [ked_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every accepted request yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc |=> out_tvalid)
    else $error("accepted request gave no result");

  // A tick never reports a hit
  a_tick_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && in_tuser == ked_pkg::ACT_TICK |=> !out_tdata[0])
    else $error("tick reported a hit");

  // A consumed event other than hold is gone from the reported flags
  a_consume: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_acc && in_tuser == ked_pkg::ACT_CHECK &&
    in_tdata[8:6] != ked_pkg::EV_HOLD && in_tdata[8:6] != ked_pkg::EV_NONE
    |=> !(out_tdata[0] &&
          ((out_tdata[7:1] >> $past(in_tdata[8:6])) & 7'd1) != 7'd0))
    else $error("consumed event still pending");

  // An accepted register write carries a known index and value
  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !$isunknown({cfg_index, cfg_data}))
    else $error("register write with unknown index or value");

endmodule

bind key_event_detector ked_checker u_ked_checker (.*);

`default_nettype wire
